// File: hdl/sph_p6_pkg.sv
// ----------------------------------------------------------------------------
// sph_p6_pkg
// Shared types, constants and saturation helper for the poly6 kernel core.
// ----------------------------------------------------------------------------
package sph_p6_pkg;

   localparam int unsigned DISP_W      = 32;
   localparam int unsigned OUT_W       = 48;
   localparam int unsigned KVAL_W      = 47;
   localparam int unsigned CSR_IDX_W   = 8;
   localparam int unsigned CSR_DATA_W  = 48;
   localparam int unsigned IN_TDATA_W  = 96;
   localparam int unsigned OUT_TDATA_W = 296;
   localparam int unsigned Q30         = 30;

   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_SQ     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_RADIUS_SQ = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_VALUE    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_DERIV    = 8'd3;

   localparam logic [32:0] ONE_Q30   = 33'h0_4000_0000;
   localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic [63:0]      d2;
      logic             in_rad;
   } sph_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sph_fifo_status_type;

   typedef struct packed {
      logic [30:0] x2;
      logic [30:0] x3;
      logic [32:0] p;
      logic        m_neg;
   } sph_poly_type;

   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             in_rad;
   } sph_side_type;

   typedef struct packed {
      logic [30:0] x3;
      logic [32:0] p;
      logic        m_neg;
      logic [2:0]  neg;
      logic        in_rad;
   } sph_tail_type;

   typedef struct packed {
      logic [47:0] val;
      logic        sat;
   } sph_sat_type;

   // Clamps a shifted magnitude and applies the sign.
   function automatic sph_sat_type sat_signed(logic [127:0] v, logic neg);
      sph_sat_type r;
      logic [47:0] lim;
      logic [47:0] mag;
      lim = neg ? NEG_LIMIT : POS_LIMIT;
      if (v > {80'd0, lim}) begin
         mag   = lim;
         r.sat = 1'b1;
      end else begin
         mag   = v[47:0];
         r.sat = 1'b0;
      end
      r.val = neg ? (48'd0 - mag) : mag;
      return r;
   endfunction

endpackage

// File: hdl/sph_p6_mul.sv
// ----------------------------------------------------------------------------
// sph_p6_mul
// Two-stage 64 x 64 unsigned multiplier built from four 32 x 32 products.
// ----------------------------------------------------------------------------
module sph_p6_mul (
   input  logic         clock,
   input  logic         en,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic [127:0] prod
);

   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff  <= a[31:0] * b[31:0];
         p01_ff  <= a[31:0] * b[63:32];
         p10_ff  <= a[63:32] * b[31:0];
         p11_ff  <= a[63:32] * b[63:32];
         prod_ff <= {64'd0, p00_ff} + {32'd0, p01_ff, 32'd0}
                    + {32'd0, p10_ff, 32'd0} + {p11_ff, 64'd0};
      end
   end

   assign prod = prod_ff;

endmodule

// File: hdl/sph_p6_sqrt.sv
// ----------------------------------------------------------------------------
// sph_p6_sqrt
// Pipelined integer square root, one result bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module sph_p6_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);

   logic [34:0] rem_ff  [0:31];
   logic [31:0] root_ff [0:31];
   logic [63:0] rad_ff  [0:31];

   for (genvar k = 0; k < 32; k++) begin : g_stage
      logic [34:0] rem_prev;
      logic [31:0] root_prev;
      logic [63:0] rad_prev;
      logic [34:0] rs;
      logic [34:0] trial;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      assign rs    = {rem_prev[32:0], rad_prev[63:62]};
      assign trial = {1'b0, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            if (rs >= trial) begin
               rem_ff[k]  <= rs - trial;
               root_ff[k] <= {root_prev[30:0], 1'b1};
            end else begin
               rem_ff[k]  <= rs;
               root_ff[k] <= {root_prev[30:0], 1'b0};
            end
            rad_ff[k] <= {rad_prev[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[31];

endmodule

// File: hdl/sph_p6_front.sv
// ----------------------------------------------------------------------------
// sph_p6_front
// Takes displacement requests, forms magnitudes and squared distance, and
// classifies each against the kernel radius.
// ----------------------------------------------------------------------------
module sph_p6_front import sph_p6_pkg::*; #(
   parameter int unsigned COORD_FRAC_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_TDATA_W-1:0] req_tdata,
   input  logic [31:0]           radius_sq,
   input  sph_fifo_status_type   fifo_status,
   output logic                  push,
   output sph_entry_type         entry
);

   logic             en;
   logic             s1_vld_ff, s2_vld_ff;
   logic [2:0][31:0] mag_in;
   logic [2:0]       neg_in;
   logic [2:0][31:0] mag_ff;
   logic [2:0]       neg_ff;
   logic [2:0][63:0] sq_ff;
   logic [63:0]      d2_in;
   logic [63:0]      lim;
   sph_entry_type    entry_ff;

   assign en         = !(s2_vld_ff && fifo_status.full);
   assign req_tready = en;
   assign push       = s2_vld_ff && !fifo_status.full;
   assign entry      = entry_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = req_tdata[DISP_W*i + DISP_W - 1];
         mag_in[i] = neg_in[i] ? (32'd0 - req_tdata[DISP_W*i +: DISP_W])
                               : req_tdata[DISP_W*i +: DISP_W];
      end
   end

   assign d2_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   assign lim   = {32'd0, radius_sq} << COORD_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= mag_in[i] * mag_in[i];
         end
         mag_ff          <= mag_in;
         neg_ff          <= neg_in;
         entry_ff.mag    <= mag_ff;
         entry_ff.neg    <= neg_ff;
         entry_ff.d2     <= d2_in;
         entry_ff.in_rad <= d2_in < lim;
      end
   end

endmodule

// File: hdl/sph_p6_fifo.sv
// ----------------------------------------------------------------------------
// sph_p6_fifo
// Small queue that decouples the front classifier from the arithmetic back end.
// ----------------------------------------------------------------------------
module sph_p6_fifo import sph_p6_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sph_entry_type       wr_data,
   input  logic                pop,
   output sph_entry_type       rd_data,
   output sph_fifo_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   sph_entry_type    mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign status.empty = count_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hdl/sph_p6_back.sv
// ----------------------------------------------------------------------------
// sph_p6_back
// Arithmetic pipeline: ratio, polynomial terms, square root, coefficient
// products and saturation, ending in the response register.
// ----------------------------------------------------------------------------
module sph_p6_back import sph_p6_pkg::*; #(
   parameter int unsigned COORD_FRAC_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sph_entry_type          head,
   input  sph_fifo_status_type    fifo_status,
   output logic                   pop,
   input  logic [47:0]            inv_radius_sq,
   input  logic [47:0]            coef_value,
   input  logic [47:0]            coef_deriv,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_TDATA_W-1:0] rsp_tdata
);

   localparam int unsigned LAT = 36;

   logic                   en;
   logic [LAT:1]           vld_ff;
   logic                   rsp_tvalid_ff;
   logic [OUT_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   sph_entry_type ent_ff;
   logic [127:0]  tprod, t_raw;
   logic [30:0]   t_in, t_ff, x_ff, x5_ff, x2_ff;
   logic [32:0]   five_t, mabs_in, mabs_ff;
   logic          mneg_ff;
   logic [61:0]   xx;
   logic [61:0]   x2x;
   logic [63:0]   xm;
   sph_poly_type  poly_ff;
   sph_poly_type  polyd_ff [0:26];
   sph_side_type  sided_ff [0:31];
   logic [31:0]   root;
   logic [62:0]   dx;
   logic [2:0][62:0] gx;
   logic [32:0]   dq_ff;
   logic [2:0][32:0] gq_ff;
   sph_tail_type  tail_ff, tail2_ff, tail3_ff;
   logic [127:0]  pv, pd, ps;
   logic [2:0][127:0] pg;
   sph_sat_type   kv, fd, sd;
   sph_sat_type   gr [0:2];

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign pop        = en && !fifo_status.empty;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   sph_p6_mul u_tmul (
      .clock (clock),
      .en    (en),
      .a     (ent_ff.d2 >> COORD_FRAC_BITS),
      .b     ({16'd0, inv_radius_sq}),
      .prod  (tprod)
   );

   sph_p6_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (ent_ff.d2),
      .root  (root)
   );

   assign t_raw   = tprod >> (COORD_FRAC_BITS - 6);
   assign t_in    = (t_raw > {95'd0, ONE_Q30}) ? ONE_Q30[30:0] : t_raw[30:0];
   assign xx      = x_ff * x_ff;
   assign five_t  = {2'b00, t_ff} * 33'd5;
   assign mabs_in = (five_t < ONE_Q30) ? (ONE_Q30 - five_t) : (five_t - ONE_Q30);
   assign x2x     = x2_ff * x5_ff;
   assign xm      = x5_ff * mabs_ff;
   assign dx      = root * polyd_ff[26].x2;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gx[i] = sided_ff[31].mag[i] * polyd_ff[26].x2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_ff           <= head;
         t_ff             <= t_in;
         x_ff             <= ONE_Q30[30:0] - t_in;
         x2_ff            <= xx[60:30];
         x5_ff            <= x_ff;
         mabs_ff          <= mabs_in;
         mneg_ff          <= five_t < ONE_Q30;
         poly_ff.x2       <= x2_ff;
         poly_ff.x3       <= x2x[60:30];
         poly_ff.p        <= xm[62:30];
         poly_ff.m_neg    <= mneg_ff;
         polyd_ff[0]      <= poly_ff;
         for (int k = 1; k < 27; k++) begin
            polyd_ff[k] <= polyd_ff[k-1];
         end
         sided_ff[0].mag    <= ent_ff.mag;
         sided_ff[0].neg    <= ent_ff.neg;
         sided_ff[0].in_rad <= ent_ff.in_rad;
         for (int k = 1; k < 32; k++) begin
            sided_ff[k] <= sided_ff[k-1];
         end
         dq_ff <= dx[62:30];
         for (int i = 0; i < 3; i++) begin
            gq_ff[i] <= gx[i][62:30];
         end
         tail_ff.x3     <= polyd_ff[26].x3;
         tail_ff.p      <= polyd_ff[26].p;
         tail_ff.m_neg  <= polyd_ff[26].m_neg;
         tail_ff.neg    <= sided_ff[31].neg;
         tail_ff.in_rad <= sided_ff[31].in_rad;
         tail2_ff       <= tail_ff;
         tail3_ff       <= tail2_ff;
         rsp_tdata_ff   <= rsp_tdata_in;
      end
   end

   sph_p6_mul u_vmul (
      .clock (clock), .en (en),
      .a ({16'd0, coef_value}), .b ({33'd0, tail_ff.x3}), .prod (pv)
   );

   sph_p6_mul u_dmul (
      .clock (clock), .en (en),
      .a ({16'd0, coef_deriv}), .b ({31'd0, dq_ff}), .prod (pd)
   );

   sph_p6_mul u_smul (
      .clock (clock), .en (en),
      .a ({16'd0, coef_deriv}), .b ({31'd0, tail_ff.p}), .prod (ps)
   );

   for (genvar i = 0; i < 3; i++) begin : g_grad
      sph_p6_mul u_gmul (
         .clock (clock), .en (en),
         .a ({16'd0, coef_deriv}), .b ({31'd0, gq_ff[i]}), .prod (pg[i])
      );
   end

   always_comb begin
      kv = sat_signed(pv >> Q30, 1'b0);
      fd = sat_signed(pd >> COORD_FRAC_BITS, 1'b1);
      sd = sat_signed(ps >> Q30, tail3_ff.m_neg);
      for (int i = 0; i < 3; i++) begin
         gr[i] = sat_signed(pg[i] >> COORD_FRAC_BITS, tail3_ff.neg[i]);
      end
      if (tail3_ff.in_rad) begin
         rsp_tdata_in = {7'd0,
                         kv.sat | fd.sat | sd.sat | gr[0].sat | gr[1].sat | gr[2].sat,
                         1'b1, gr[2].val, gr[1].val, gr[0].val, sd.val, fd.val,
                         kv.val[KVAL_W-1:0]};
      end else begin
         rsp_tdata_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[LAT-1:1], pop};
         rsp_tvalid_ff <= vld_ff[LAT];
      end
   end

endmodule

// File: hdl/sph_poly6_kernel_3d_core.sv
// ----------------------------------------------------------------------------
// sph_poly6_kernel_3d_core
// Poly6 SPH kernel: value, radial derivatives and gradient of one displacement.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle when the response side keeps up.
// Latency is set mostly by the 32-stage square root in the back end; a
// four-entry queue sits between the front classifier and the back end. Reset
// is synchronous and active high; it empties the pipeline and queue and
// clears all configuration registers.
module sph_poly6_kernel_3d_core import sph_p6_pkg::*; #(
   parameter int unsigned COORD_FRAC_BITS = 24,
   parameter int unsigned FIFO_DEPTH      = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // disp_x, disp_y, disp_z
   input  logic [IN_TDATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // kernel_value, first_deriv, second_deriv, grad_x, grad_y, grad_z,
   // inside_res, saturated, zero fill
   output logic [OUT_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [31:0]         radius_sq_ff;
   logic [47:0]         inv_radius_sq_ff, coef_value_ff, coef_deriv_ff;
   logic                push, pop;
   sph_entry_type       entry, head;
   sph_fifo_status_type fifo_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff     <= '0;
         inv_radius_sq_ff <= '0;
         coef_value_ff    <= '0;
         coef_deriv_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RADIUS_SQ:     radius_sq_ff     <= csr_wdata[31:0];
            REG_INV_RADIUS_SQ: inv_radius_sq_ff <= csr_wdata;
            REG_COEF_VALUE:    coef_value_ff    <= csr_wdata;
            REG_COEF_DERIV:    coef_deriv_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   sph_p6_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .radius_sq   (radius_sq_ff),
      .fifo_status (fifo_status),
      .push        (push),
      .entry       (entry)
   );

   sph_p6_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (entry),
      .pop     (pop),
      .rd_data (head),
      .status  (fifo_status)
   );

   sph_p6_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .fifo_status   (fifo_status),
      .pop           (pop),
      .inv_radius_sq (inv_radius_sq_ff),
      .coef_value    (coef_value_ff),
      .coef_deriv    (coef_deriv_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[287] |-> rsp_tdata[288:0] == '0)
      else $error("Outside result carries nonzero fields.");

   a_deriv_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[94:47] == '0) || rsp_tdata[94])
      else $error("First derivative is positive.");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_status.full)
      else $error("Queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("Queue read while empty.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response valid right after reset.");

endmodule
